// ===== src/pcrq_pkg.sv =====
package pcrq_pkg;

	localparam int IdW   = 7;
	localparam int PrioW = 8;

	typedef logic [1:0] status_t;
	localparam status_t ST_DONE     = 2'd0;
	localparam status_t ST_FULL     = 2'd1;
	localparam status_t ST_NOTFOUND = 2'd2;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_REMOVE = 1'b1;

	typedef struct packed {
		logic [IdW-1:0]   id;
		logic [PrioW-1:0] prio;
		logic [PrioW-1:0] ceiling;
		logic             elevated;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_CMP  = 5'b00100,
		S_SRD  = 5'b01000,
		S_SWR  = 5'b10000
	} state_t;

	// new entry goes ahead of stored entry s
	function automatic logic goes_before(entry_t s, entry_t n);
		logic r;
		r = (s.elevated && (s.ceiling < n.prio))
			|| (n.elevated && (s.prio < n.ceiling))
			|| (s.prio < n.prio);
		return r;
	endfunction

endpackage

// ===== src/priority_ceiling_ready_queue_top.sv =====
// an insert into a full queue or a remove from an empty one answers the cycle after start;
// otherwise read+compare per entry scanned, read+write per entry shifted, plus one write on insert
// one operation at a time: busy is high until the done beat
// the pace is set by the single registered read port of the entry memory
// reset: arst_n clears the count and the control state, the queue reads empty; memory is not cleared
// the receiver cannot stall: each result is a single-cycle done beat
module priority_ceiling_ready_queue_top #(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     mode,
	input  logic [pcrq_pkg::IdW-1:0] task_id,
	input  logic [7:0]               prio,
	input  logic [7:0]               ceiling,
	input  logic                     elevated,
	output logic                     done,
	output logic [1:0]               status,
	output logic                     head_valid,
	output logic [6:0]               head_task_id,
	output logic [3:0]               occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	pcrq_pkg::state_t state_q;
	logic [CW-1:0]    cnt_q;
	logic [AW-1:0]    k_q;       // scan index
	logic [AW-1:0]    j_q;       // shift destination
	logic [AW-1:0]    pos_q;     // insert slot
	logic             mode_q;
	pcrq_pkg::entry_t new_q;     // the operation's own entry
	pcrq_pkg::entry_t head_q;    // copy of slot 0
	logic             done_q;
	pcrq_pkg::status_t status_q;

	logic             we;
	logic [AW-1:0]    waddr;
	pcrq_pkg::entry_t wdata;
	logic [AW-1:0]    raddr;
	pcrq_pkg::entry_t rdata;
	logic             hit;
	logic             accept;

	// the new entry is written through a dedicated path, merged with the shift write
	logic             ins_we;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	pcrq_pkg::entry_t mem_wdata;
	logic             ins_pend_q;   // new entry waits for its write cycle

	assign accept = start && !busy;
	assign busy   = (state_q != pcrq_pkg::S_IDLE);

	pcrq_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// match test on the entry read back from the memory
	always_comb begin
		if (mode_q == pcrq_pkg::MODE_INSERT) begin
			hit = pcrq_pkg::goes_before(rdata, new_q);
		end else begin
			hit = (rdata.id == new_q.id);
		end
	end

	// read address: scan slot, or the neighbour that moves into j
	always_comb begin
		raddr = k_q;
		if (state_q == pcrq_pkg::S_SRD) begin
			if (mode_q == pcrq_pkg::MODE_INSERT) begin
				raddr = j_q - AW'(1);
			end else begin
				raddr = j_q + AW'(1);
			end
		end
	end

	// shift moves the read data into slot j
	always_comb begin
		we    = 1'b0;
		waddr = j_q;
		wdata = rdata;
		if (state_q == pcrq_pkg::S_SWR) begin
			we = 1'b1;
		end
	end

	assign ins_we    = ins_pend_q;
	assign mem_we    = we || ins_we;
	assign mem_waddr = ins_we ? pos_q : waddr;
	assign mem_wdata = ins_we ? new_q : wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcrq_pkg::S_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			ins_pend_q <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			ins_pend_q <= 1'b0;
			if (ins_pend_q) begin
				// insert write happens this cycle; the done beat and the count are registered at its end
				cnt_q    <= cnt_q + CW'(1);
				done_q   <= 1'b1;
				status_q <= pcrq_pkg::ST_DONE;
			end
			case (state_q)
				pcrq_pkg::S_IDLE: begin
					if (accept) begin
						k_q <= '0;
						if (mode == pcrq_pkg::MODE_INSERT) begin
							if (cnt_q == CW'(DEPTH)) begin
								done_q   <= 1'b1;
								status_q <= pcrq_pkg::ST_FULL;
							end else if (cnt_q == '0) begin
								pos_q      <= '0;
								ins_pend_q <= 1'b1;
								state_q    <= pcrq_pkg::S_SWR;
							end else begin
								state_q <= pcrq_pkg::S_RD;
							end
						end else begin
							if (cnt_q == '0) begin
								done_q   <= 1'b1;
								status_q <= pcrq_pkg::ST_NOTFOUND;
							end else begin
								state_q <= pcrq_pkg::S_RD;
							end
						end
					end
				end
				pcrq_pkg::S_RD: begin
					state_q <= pcrq_pkg::S_CMP;
				end
				pcrq_pkg::S_CMP: begin
					if (hit) begin
						pos_q <= k_q;
						if (mode_q == pcrq_pkg::MODE_INSERT) begin
							j_q     <= AW'(cnt_q);
							state_q <= pcrq_pkg::S_SRD;
						end else if (CW'(k_q) + CW'(1) == cnt_q) begin
							cnt_q    <= cnt_q - CW'(1);
							done_q   <= 1'b1;
							status_q <= pcrq_pkg::ST_DONE;
							state_q  <= pcrq_pkg::S_IDLE;
						end else begin
							j_q     <= k_q;
							state_q <= pcrq_pkg::S_SRD;
						end
					end else if (CW'(k_q) + CW'(1) == cnt_q) begin
						if (mode_q == pcrq_pkg::MODE_INSERT) begin
							pos_q      <= AW'(cnt_q);
							ins_pend_q <= 1'b1;
							state_q    <= pcrq_pkg::S_SWR;
						end else begin
							done_q   <= 1'b1;
							status_q <= pcrq_pkg::ST_NOTFOUND;
							state_q  <= pcrq_pkg::S_IDLE;
						end
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= pcrq_pkg::S_RD;
					end
				end
				pcrq_pkg::S_SRD: begin
					state_q <= pcrq_pkg::S_SWR;
				end
				pcrq_pkg::S_SWR: begin
					if (ins_pend_q) begin
						// new entry written this cycle
						state_q <= pcrq_pkg::S_IDLE;
					end else if (mode_q == pcrq_pkg::MODE_INSERT) begin
						j_q <= j_q - AW'(1);
						if (j_q - AW'(1) == pos_q) begin
							ins_pend_q <= 1'b1;
							state_q    <= pcrq_pkg::S_SWR;
						end else begin
							state_q <= pcrq_pkg::S_SRD;
						end
					end else begin
						j_q <= j_q + AW'(1);
						if (CW'(j_q) + CW'(2) == cnt_q) begin
							cnt_q    <= cnt_q - CW'(1);
							done_q   <= 1'b1;
							status_q <= pcrq_pkg::ST_DONE;
							state_q  <= pcrq_pkg::S_IDLE;
						end else begin
							state_q <= pcrq_pkg::S_SRD;
						end
					end
				end
				default: begin
					state_q <= pcrq_pkg::S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q            <= mode;
			new_q.id          <= task_id;
			new_q.prio        <= prio;
			new_q.ceiling     <= ceiling;
			new_q.elevated    <= elevated;
		end
		// slot 0 mirror for the head outputs
		if (mem_we && mem_waddr == '0) begin
			head_q <= mem_wdata;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign head_valid   = (cnt_q != '0);
	assign head_task_id = (cnt_q != '0) ? head_q.id : '0;
	assign occupancy    = 4'(cnt_q);

endmodule

// ===== src/pcrq_mem.sv =====
module pcrq_mem #(
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  pcrq_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output pcrq_pkg::entry_t         rdata
);

	pcrq_pkg::entry_t mem [DEPTH];
	pcrq_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/pcrq_checker.sv =====
module pcrq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic       head_valid,
	input logic [6:0] head_task_id,
	input logic [3:0] occupancy
);

	// an accepted beat either starts work or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted beat neither busy nor answered");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while still busy");

	a_occ_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occupancy) |-> done)
		else $error("occupancy moved without a result beat");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (head_task_id == 7'd0))
		else $error("empty queue shows a head id");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status != 2'd3))
		else $error("undefined status code");

endmodule

bind priority_ceiling_ready_queue_top pcrq_checker u_pcrq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.head_valid   (head_valid),
	.head_task_id (head_task_id),
	.occupancy    (occupancy)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int DEPTH = 8;
	localparam int WATCHDOG_LIMIT = 2000;

	// scoreboard: models the ready queue and holds expected done beats
	class ready_queue_board;
		pcrq_pkg::entry_t slots[$];
		pcrq_pkg::status_t exp_status[$];
		logic exp_valid[$];
		logic [6:0] exp_head[$];
		logic [3:0] exp_occ[$];
		int errors;

		function void note_command(logic m, logic [6:0] id, logic [7:0] p,
			logic [7:0] c, logic e);
			pcrq_pkg::entry_t n;
			pcrq_pkg::status_t st;
			int pos;
			st = pcrq_pkg::ST_DONE;
			n.id = id; n.prio = p; n.ceiling = c; n.elevated = e;
			if (m == pcrq_pkg::MODE_INSERT) begin
				if (slots.size() >= DEPTH) begin
					st = pcrq_pkg::ST_FULL;
				end else begin
					pos = slots.size();
					for (int k = 0; k < slots.size(); k++) begin
						if ((slots[k].elevated && slots[k].ceiling < p)
							|| (e && slots[k].prio < c) || (slots[k].prio < p)) begin
							pos = k;
							break;
						end
					end
					slots.insert(pos, n);
				end
			end else begin
				pos = -1;
				for (int k = 0; k < slots.size(); k++) begin
					if (slots[k].id == id) begin
						pos = k;
						break;
					end
				end
				if (pos < 0) st = pcrq_pkg::ST_NOTFOUND;
				else slots.delete(pos);
			end
			exp_status.push_back(st);
			exp_valid.push_back(slots.size() > 0);
			exp_head.push_back(slots.size() > 0 ? slots[0].id : 7'd0);
			exp_occ.push_back(4'(slots.size()));
		endfunction

		function void check_done(logic [1:0] st, logic hv, logic [6:0] hid, logic [3:0] occ);
			logic [1:0] es;
			logic ev;
			logic [6:0] eh;
			logic [3:0] eo;
			if (exp_status.size() == 0) begin
				$display("%0t: unexpected done beat, status %0d head %0d occ %0d",
					$time, st, hid, occ);
				errors++;
				return;
			end
			es = exp_status.pop_front(); ev = exp_valid.pop_front();
			eh = exp_head.pop_front(); eo = exp_occ.pop_front();
			if (st !== es) begin
				$display("%0t: status expected %0d actual %0d", $time, es, st);
				errors++;
			end
			if (hv !== ev) begin
				$display("%0t: head_valid expected %0d actual %0d", $time, ev, hv);
				errors++;
			end
			if (hid !== eh) begin
				$display("%0t: head_task_id expected %0d actual %0d", $time, eh, hid);
				errors++;
			end
			if (occ !== eo) begin
				$display("%0t: occupancy expected %0d actual %0d", $time, eo, occ);
				errors++;
			end
		endfunction

		function int pending();
			return exp_status.size();
		endfunction

		function logic [6:0] some_held_id();
			if (slots.size() == 0) return 7'($urandom_range(0, 127));
			return slots[$urandom_range(0, slots.size() - 1)].id;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic mode = pcrq_pkg::MODE_INSERT;
	logic [6:0] task_id = '0;
	logic [7:0] prio = '0;
	logic [7:0] ceiling = '0;
	logic elevated = 1'b0;
	logic done;
	logic [1:0] status;
	logic head_valid;
	logic [6:0] head_task_id;
	logic [3:0] occupancy;

	ready_queue_board board = new();
	int idle_cycles = 0;
	bit no_gaps = 1'b0;

	priority_ceiling_ready_queue_top #(.DEPTH(DEPTH)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.task_id(task_id), .prio(prio), .ceiling(ceiling), .elevated(elevated),
		.done(done), .status(status), .head_valid(head_valid),
		.head_task_id(head_task_id), .occupancy(occupancy)
	);

	always #2 clk = ~clk;

	// sample done beats and the accepted command at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_done(status, head_valid, head_task_id, occupancy);
			if (start && !busy) board.note_command(mode, task_id, prio, ceiling, elevated);
			if (done || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// watchdog on cycles without any accepted beat or done beat
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// present one command beat at a falling edge and hold it until accepted;
	// start stays high afterwards unless the next call idles first
	task automatic send_cmd(logic m, logic [6:0] id, logic [7:0] p, logic [7:0] c, logic e);
		while (!no_gaps && $urandom_range(0, 99) < 31) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode <= m; task_id <= id; prio <= p; ceiling <= c; elevated <= e;
		while (busy) @(negedge clk);
		@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random();
		logic m;
		logic [6:0] id;
		// bias towards inserts while light and removes of held ids while heavy
		m = ($urandom_range(0, 99) < (board.slots.size() * 10 + 15)) ?
			pcrq_pkg::MODE_REMOVE : pcrq_pkg::MODE_INSERT;
		if (m == pcrq_pkg::MODE_REMOVE && $urandom_range(0, 9) < 8) id = board.some_held_id();
		else id = 7'($urandom_range(0, 127));
		// small priority range now and then to get ties and duplicates
		if ($urandom_range(0, 3) == 0)
			send_cmd(m, id & 7'h7, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				1'($urandom));
		else
			send_cmd(m, id, 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: remove from empty, extremes, ties, full, not found, last entry out
		send_cmd(pcrq_pkg::MODE_REMOVE, 7'd5, 8'd0, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd127, 8'd0, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_REMOVE, 7'd127, 8'd0, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd0, 8'd255, 8'd255, 1'b1);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd1, 8'd10, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd2, 8'd10, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd3, 8'd5, 8'd200, 1'b1);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd4, 8'd20, 8'd30, 1'b1);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd2, 8'd0, 8'd255, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd6, 8'd255, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd7, 8'd1, 8'd1, 1'b1);
		send_cmd(pcrq_pkg::MODE_INSERT, 7'd8, 8'd100, 8'd100, 1'b0);
		send_cmd(pcrq_pkg::MODE_REMOVE, 7'd99, 8'd0, 8'd0, 1'b0);
		send_cmd(pcrq_pkg::MODE_REMOVE, 7'd2, 8'hff, 8'hff, 1'b1);
		send_cmd(pcrq_pkg::MODE_REMOVE, 7'd0, 8'd0, 8'd0, 1'b0);
		repeat (DEPTH) send_cmd(pcrq_pkg::MODE_REMOVE, board.some_held_id(), 8'd0, 8'd0, 1'b0);

		// random part, with a stretch without gaps in the middle
		for (int i = 0; i < 900; i++) begin
			no_gaps = (i >= 300 && i < 450);
			send_random();
		end
		start <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (4 * DEPTH + 8) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== priority_ceiling_ready_queue_top.f =====
src/pcrq_pkg.sv
src/pcrq_mem.sv
src/priority_ceiling_ready_queue_top.sv
src/pcrq_checker.sv
tb/tb.sv
